### src/mcps_pkg.sv
// shared types and constants of the multi-channel power sequencer
package mcps_pkg;

  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 16;
  localparam int SLOT_BITS = 16;
  localparam int REG_BITS  = 64;
  localparam int IDX_BITS  = 3;
  localparam int FLAG_BITS = 4;

  typedef logic [TIME_BITS-1:0] ticks_t;
  typedef logic [IDX_BITS-1:0]  cfg_index_t;

  localparam ticks_t TIME_MAX = '1;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam cfg_index_t REG_ON_DELAY   = 3'd0;
  localparam cfg_index_t REG_ON_HOLD    = 3'd1;
  localparam cfg_index_t REG_ON_SETTLE  = 3'd2;
  localparam cfg_index_t REG_OFF_DELAY  = 3'd3;
  localparam cfg_index_t REG_OFF_HOLD   = 3'd4;
  localparam cfg_index_t REG_OFF_SETTLE = 3'd5;

  typedef enum logic [1:0] {
    PH_DELAY  = 2'd0,
    PH_HOLD   = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  typedef struct packed {
    ticks_t delay;
    ticks_t hold;
    ticks_t settle;
  } phase_len_t;

  typedef struct packed {
    phase_len_t on;
    phase_len_t off;
  } chan_len_t;

  typedef struct packed {
    logic tick;
    logic req_hit;
    logic turn_on;
  } chan_step_t;

  typedef struct packed {
    logic line;
    logic powered;
    logic running;
    logic rail;
  } chan_status_t;

endpackage

### src/multi_channel_power_sequencer.sv
// top level of the multi-channel power sequencer
// Each input word is either a time tick (tuser 0) or a power request (tuser 1) for one
// channel or for all channels. Every accepted word produces one result word holding the
// control line, power state, busy and rail-off flags of all channels after the update.
// A word is registered on input; once the output register is free, all channels update
// in parallel and the result lands in it: one word per cycle sustained, with both sides
// free to stall. The phase length registers sit on a separate write port; the user must
// write them only while the block is idle, as the block itself does not enforce this.
module multi_channel_power_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // channel, all_channels, turn_on
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // control_lines, device_on, busy_res, rail_off
  output logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mcps_pkg::cfg_index_t          cfg_index,
  input  logic [mcps_pkg::REG_BITS-1:0] cfg_data
);

  localparam int FW = mcps_pkg::FLAG_BITS;
  localparam int CH = mcps_pkg::CHANNELS;

  logic       in_valid;
  logic       in_mode;
  logic [1:0] in_channel;
  logic       in_all;
  logic       in_on;
  logic       advance;

  logic          out_valid;
  logic [FW-1:0] out_lines;
  logic [FW-1:0] out_on;
  logic [FW-1:0] out_busy;
  logic [FW-1:0] out_rail;

  mcps_pkg::chan_len_t    lens   [CH];
  mcps_pkg::chan_step_t   steps  [CH];
  mcps_pkg::chan_status_t status [CH];

  logic [FW-1:0] lines_next;
  logic [FW-1:0] on_next;
  logic [FW-1:0] busy_next;
  logic [FW-1:0] rail_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode    <= s_axis_tuser;
      in_channel <= s_axis_tdata[1:0];
      in_all     <= s_axis_tdata[2];
      in_on      <= s_axis_tdata[3];
    end
  end

  mcps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lens      (lens)
  );

  for (genvar c = 0; c < CH; c++) begin : g_chan
    assign steps[c].tick    = advance && (in_mode == mcps_pkg::MODE_TICK);
    assign steps[c].req_hit = advance && (in_mode == mcps_pkg::MODE_REQUEST) &&
                              (in_all || (in_channel == 2'(c)));
    assign steps[c].turn_on = in_on;

    mcps_channel u_channel (
      .clk    (clk),
      .rst    (rst),
      .step   (steps[c]),
      .lens   (lens[c]),
      .status (status[c])
    );
  end

  always_comb begin
    lines_next = '0;
    on_next    = '0;
    busy_next  = '0;
    rail_next  = '0;
    for (int c = 0; c < CH; c++) begin
      lines_next[c] = status[c].line;
      on_next[c]    = status[c].powered;
      busy_next[c]  = status[c].running;
      rail_next[c]  = status[c].rail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_lines <= lines_next;
      out_on    <= on_next;
      out_busy  <= busy_next;
      out_rail  <= rail_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_rail, out_busy, out_on, out_lines};

`ifndef SYNTH
  a_rail_means_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_rail & (out_on | out_busy)) == '0))
    else $error("rail-off pulse on a channel that is on or still busy");

  a_line_means_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_lines & ~out_busy) == '0))
    else $error("control line asserted on an idle channel");

  a_request_no_rail: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_mode == mcps_pkg::MODE_REQUEST)) |=> (out_rail == '0))
    else $error("rail-off pulse in the result of a request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

### src/mcps_cfg_regs.sv
// phase length registers and per channel slot extraction
module mcps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mcps_pkg::cfg_index_t          cfg_index,
  input  logic [mcps_pkg::REG_BITS-1:0] cfg_data,
  output mcps_pkg::chan_len_t           lens [mcps_pkg::CHANNELS]
);

  logic [mcps_pkg::REG_BITS-1:0] on_delay;
  logic [mcps_pkg::REG_BITS-1:0] on_hold;
  logic [mcps_pkg::REG_BITS-1:0] on_settle;
  logic [mcps_pkg::REG_BITS-1:0] off_delay;
  logic [mcps_pkg::REG_BITS-1:0] off_hold;
  logic [mcps_pkg::REG_BITS-1:0] off_settle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_delay   <= '0;
      on_hold    <= '0;
      on_settle  <= '0;
      off_delay  <= '0;
      off_hold   <= '0;
      off_settle <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mcps_pkg::REG_ON_DELAY:   on_delay   <= cfg_data;
        mcps_pkg::REG_ON_HOLD:    on_hold    <= cfg_data;
        mcps_pkg::REG_ON_SETTLE:  on_settle  <= cfg_data;
        mcps_pkg::REG_OFF_DELAY:  off_delay  <= cfg_data;
        mcps_pkg::REG_OFF_HOLD:   off_hold   <= cfg_data;
        mcps_pkg::REG_OFF_SETTLE: off_settle <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < mcps_pkg::CHANNELS; c++) begin : g_slot
    localparam int LO = mcps_pkg::SLOT_BITS * c;
    assign lens[c].on.delay   = on_delay[LO +: mcps_pkg::TIME_BITS];
    assign lens[c].on.hold    = on_hold[LO +: mcps_pkg::TIME_BITS];
    assign lens[c].on.settle  = on_settle[LO +: mcps_pkg::TIME_BITS];
    assign lens[c].off.delay  = off_delay[LO +: mcps_pkg::TIME_BITS];
    assign lens[c].off.hold   = off_hold[LO +: mcps_pkg::TIME_BITS];
    assign lens[c].off.settle = off_settle[LO +: mcps_pkg::TIME_BITS];
  end

endmodule

### src/mcps_channel.sv
// state and phase sequencing of one channel
module mcps_channel (
  input  logic                   clk,
  input  logic                   rst,
  input  mcps_pkg::chan_step_t   step,
  input  mcps_pkg::chan_len_t    lens,
  output mcps_pkg::chan_status_t status
);

  mcps_pkg::phase_t phase;
  mcps_pkg::phase_t phase_next;
  logic             powered;
  logic             powered_next;
  logic             running;
  logic             running_next;
  logic             line_level;
  logic             line_level_next;
  mcps_pkg::ticks_t elapsed;
  mcps_pkg::ticks_t elapsed_next;

  mcps_pkg::phase_len_t dir_len;
  mcps_pkg::ticks_t     cur_len;
  mcps_pkg::ticks_t     count_up;
  logic                 phase_done;
  logic                 rail;

  always_comb begin
    dir_len  = powered ? lens.off : lens.on;
    count_up = (elapsed == mcps_pkg::TIME_MAX) ? elapsed : elapsed + mcps_pkg::ticks_t'(1);
    case (phase)
      mcps_pkg::PH_HOLD:   cur_len = dir_len.hold;
      mcps_pkg::PH_SETTLE: cur_len = dir_len.settle;
      default:             cur_len = dir_len.delay;
    endcase
    phase_done = count_up >= cur_len;
  end

  always_comb begin
    phase_next      = phase;
    powered_next    = powered;
    running_next    = running;
    line_level_next = line_level;
    elapsed_next    = elapsed;
    rail            = 1'b0;
    if (step.tick && running) begin
      if (!phase_done) begin
        elapsed_next = count_up;
      end else begin
        elapsed_next = '0;
        case (phase)
          mcps_pkg::PH_HOLD: begin
            line_level_next = 1'b0;
            phase_next      = mcps_pkg::PH_SETTLE;
          end
          mcps_pkg::PH_SETTLE: begin
            phase_next   = mcps_pkg::PH_DELAY;
            running_next = 1'b0;
            rail         = powered;
            powered_next = !powered;
          end
          default: begin
            line_level_next = 1'b1;
            phase_next      = mcps_pkg::PH_HOLD;
          end
        endcase
      end
    end
    if (step.req_hit && (powered != step.turn_on)) begin
      running_next = 1'b1;
      elapsed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mcps_pkg::PH_DELAY;
      powered    <= 1'b0;
      running    <= 1'b0;
      line_level <= 1'b0;
      elapsed    <= '0;
    end else begin
      phase      <= phase_next;
      powered    <= powered_next;
      running    <= running_next;
      line_level <= line_level_next;
      elapsed    <= elapsed_next;
    end
  end

  assign status.line    = line_level_next;
  assign status.powered = powered_next;
  assign status.running = running_next;
  assign status.rail    = rail;

endmodule
